FILE: sv/arpc_pkg.sv
package arpc_pkg;

  localparam int unsigned SLOT_W = 7;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned MAC_W  = 48;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_INVAL  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [KEY_W-1:0]  ip_address;
    logic [MAC_W-1:0]  mac_address;
    logic              mac_present;
    logic [7:0]        interface_index;
    logic [7:0]        hardware_type;
    logic [15:0]       connection_handle;
    logic              force_write;
  } arpc_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic [MAC_W-1:0]  found_mac;
    logic [7:0]        found_interface;
    logic [7:0]        found_hw_type;
    logic [15:0]       found_connection;
  } arpc_out_t;

  // Stored per-entry attributes; also what a hit carries down the chain.
  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [7:0]       ifx;
    logic [7:0]       hwt;
    logic [15:0]      conn;
  } entry_data_t;

  // Scan token control bits passed cell to cell.
  typedef struct packed {
    logic active;
    logic found;
    logic inv_found;
  } tok_ctrl_t;

  // Write-back command broadcast to all cells.
  typedef struct packed {
    logic set;
    logic clear;
    logic mac_we;
  } wr_cmd_t;

endpackage

FILE: sv/arpc_cell.sv
module arpc_cell
  import arpc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 128,
  parameter int unsigned INDEX         = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     used_count_i,
  input  logic [KEY_W-1:0]                       key_i,
  input  tok_ctrl_t                              tok_ctrl_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]       hit_idx_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]       inv_idx_i,
  input  entry_data_t                            hit_data_i,
  output tok_ctrl_t                              tok_ctrl_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0]       hit_idx_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0]       inv_idx_o,
  output entry_data_t                            hit_data_o,
  input  wr_cmd_t                                wr_cmd_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]       wr_idx_i,
  input  entry_data_t                            wr_data_i
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES+1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic              valid_q;
  logic [KEY_W-1:0]  ip_q;
  entry_data_t       data_q;

  tok_ctrl_t         ctrl_d, ctrl_q;
  logic [IDX_W-1:0]  hit_idx_d, hit_idx_q;
  logic [IDX_W-1:0]  inv_idx_d, inv_idx_q;
  entry_data_t       hit_data_d, hit_data_q;

  logic in_use;
  logic wr_sel;

  assign in_use = MY_CNT < used_count_i;
  assign wr_sel = wr_idx_i == MY_IDX;

  always_comb begin
    ctrl_d     = tok_ctrl_i;
    hit_idx_d  = hit_idx_i;
    inv_idx_d  = inv_idx_i;
    hit_data_d = hit_data_i;
    if (tok_ctrl_i.active && in_use && !tok_ctrl_i.found) begin
      if (valid_q && ip_q == key_i) begin
        ctrl_d.found = 1'b1;
        hit_idx_d    = MY_IDX;
        hit_data_d   = data_q;
      end else if (!valid_q) begin
        // later free slots override earlier ones
        ctrl_d.inv_found = 1'b1;
        inv_idx_d        = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      ctrl_q <= ctrl_d;
      if (wr_sel && wr_cmd_i.set) begin
        valid_q <= 1'b1;
      end else if (wr_sel && wr_cmd_i.clear) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    inv_idx_q  <= inv_idx_d;
    hit_data_q <= hit_data_d;
    if (wr_sel && wr_cmd_i.set) begin
      ip_q        <= key_i;
      data_q.ifx  <= wr_data_i.ifx;
      data_q.hwt  <= wr_data_i.hwt;
      data_q.conn <= wr_data_i.conn;
      if (wr_cmd_i.mac_we) begin
        data_q.mac <= wr_data_i.mac;
      end
    end
  end

  assign tok_ctrl_o = ctrl_q;
  assign hit_idx_o  = hit_idx_q;
  assign inv_idx_o  = inv_idx_q;
  assign hit_data_o = hit_data_q;

endmodule

FILE: sv/arp_cache_table_unit.sv
// ARP cache of TABLE_ENTRIES slots keyed by IPv4 address. Each slot lives in
// its own cell; a request launches a scan token that walks the cell chain one
// cell per clock, picking up the first valid match (and the last free slot for
// forced updates). The token starts at start_q, passes the register of every cell
// and is latched into the fin registers; the write-back/result then follows in
// S_FIN, where it waits while the output register is stalled. A new request is
// taken once write-back is done, even while the previous result is still
// stalled in the output register. Lookup data of an entry created without a
// MAC address is undefined until one is written.
module arp_cache_table_unit
  import arpc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  arpc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output arpc_out_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES+1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  state_e           state_q;
  logic             start_q;
  logic             out_valid_q;
  logic [CNT_W-1:0] cnt_q;
  logic             fin_found_q;
  logic             fin_inv_found_q;

  arpc_in_t         req_q;
  arpc_out_t        out_q;
  logic [IDX_W-1:0] fin_hit_idx_q;
  logic [IDX_W-1:0] fin_inv_idx_q;
  entry_data_t      fin_data_q;

  tok_ctrl_t        ctrl_w     [TABLE_ENTRIES+1];
  logic [IDX_W-1:0] hit_idx_w  [TABLE_ENTRIES+1];
  logic [IDX_W-1:0] inv_idx_w  [TABLE_ENTRIES+1];
  entry_data_t      hit_data_w [TABLE_ENTRIES+1];

  logic             accept;
  logic             commit;
  logic             tok_done;
  wr_cmd_t          wr_cmd;
  logic [IDX_W-1:0] wr_idx;
  entry_data_t      wr_data;
  logic             dec_append;
  arpc_out_t        dec_out;

  assign in_stall_o  = state_q != S_IDLE;
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign tok_done    = ctrl_w[TABLE_ENTRIES].active;
  assign commit      = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  assign ctrl_w[0]     = '{active: start_q, found: 1'b0, inv_found: 1'b0};
  assign hit_idx_w[0]  = '0;
  assign inv_idx_w[0]  = '0;
  assign hit_data_w[0] = '0;

  assign wr_data = '{mac:  req_q.mac_address,
                     ifx:  req_q.interface_index,
                     hwt:  req_q.hardware_type,
                     conn: req_q.connection_handle};

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    arpc_cell #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .INDEX        (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .used_count_i(cnt_q),
      .key_i       (req_q.ip_address),
      .tok_ctrl_i  (ctrl_w[g]),
      .hit_idx_i   (hit_idx_w[g]),
      .inv_idx_i   (inv_idx_w[g]),
      .hit_data_i  (hit_data_w[g]),
      .tok_ctrl_o  (ctrl_w[g+1]),
      .hit_idx_o   (hit_idx_w[g+1]),
      .inv_idx_o   (inv_idx_w[g+1]),
      .hit_data_o  (hit_data_w[g+1]),
      .wr_cmd_i    (wr_cmd),
      .wr_idx_i    (wr_idx),
      .wr_data_i   (wr_data)
    );
  end

  // Resolve the finished scan into a write-back and a result.
  always_comb begin
    wr_cmd     = '0;
    wr_idx     = fin_hit_idx_q;
    dec_append = 1'b0;
    dec_out    = '0;
    dec_out.status = ST_MISS;
    unique case (req_q.kind)
      KIND_LOOKUP: begin
        if (fin_found_q) begin
          dec_out.status           = ST_OK;
          dec_out.slot_index       = SLOT_W'(fin_hit_idx_q);
          dec_out.found_mac        = fin_data_q.mac;
          dec_out.found_interface  = fin_data_q.ifx;
          dec_out.found_hw_type    = fin_data_q.hwt;
          dec_out.found_connection = fin_data_q.conn;
        end
      end
      KIND_UPDATE: begin
        if (fin_found_q) begin
          wr_cmd.set = 1'b1;
        end else if (req_q.force_write) begin
          if (fin_inv_found_q) begin
            wr_cmd.set = 1'b1;
            wr_idx     = fin_inv_idx_q;
          end else if (cnt_q == CNT_FULL) begin
            dec_out.status = ST_FULL;
          end else begin
            wr_cmd.set = 1'b1;
            dec_append = 1'b1;
            wr_idx     = cnt_q[IDX_W-1:0];
          end
        end
        if (wr_cmd.set) begin
          wr_cmd.mac_we      = req_q.mac_present;
          dec_out.status     = ST_OK;
          dec_out.slot_index = SLOT_W'(wr_idx);
        end
      end
      KIND_INVAL: begin
        if (fin_found_q) begin
          wr_cmd.clear       = 1'b1;
          dec_out.status     = ST_OK;
          dec_out.slot_index = SLOT_W'(fin_hit_idx_q);
        end
      end
      default: begin
        dec_out.status = ST_MISS;
      end
    endcase
    if (!commit) begin
      wr_cmd     = '0;
      dec_append = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      start_q         <= 1'b0;
      out_valid_q     <= 1'b0;
      cnt_q           <= '0;
      fin_found_q     <= 1'b0;
      fin_inv_found_q <= 1'b0;
    end else begin
      start_q <= accept;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (dec_append) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tok_done) begin
            fin_found_q     <= ctrl_w[TABLE_ENTRIES].found;
            fin_inv_found_q <= ctrl_w[TABLE_ENTRIES].inv_found;
            state_q         <= S_FIN;
          end
        end
        S_FIN: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    if (tok_done) begin
      fin_hit_idx_q <= hit_idx_w[TABLE_ENTRIES];
      fin_inv_idx_q <= inv_idx_w[TABLE_ENTRIES];
      fin_data_q    <= hit_data_w[TABLE_ENTRIES];
    end
    if (commit) begin
      out_q <= dec_out;
    end
  end

endmodule
